### design/deadline_timer_queue_core_defines.svh
// assertion macros for the deadline timer queue
// no dependencies
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/dtq_pkg.sv
// types and constants of the deadline timer queue
// no dependencies
package dtq_pkg;
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TIME_W = 32;
    localparam int SEQ_W  = 32;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_CANCEL,
        ST_MARK,
        ST_PICK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              busy;
        logic              due;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] dl;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] nd;
        logic [SEQ_W-1:0]  seq;
    } entry_t;
endpackage

### design/dtq_cell.sv
// one timer slot of the rotating ring
// depends on dtq_pkg
module dtq_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dtq_pkg::SLOT_W-1:0] init_slot,
    input  logic                       shift_en,
    input  dtq_pkg::entry_t            d,
    output dtq_pkg::entry_t            q
);
    logic                       busy_reg;
    logic                       due_reg;
    logic [dtq_pkg::SLOT_W-1:0] slot_reg;
    logic [dtq_pkg::TIME_W-1:0] dl_reg;
    logic [dtq_pkg::TIME_W-1:0] per_reg;
    logic [dtq_pkg::TIME_W-1:0] nd_reg;
    logic [dtq_pkg::SEQ_W-1:0]  seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            due_reg  <= 1'b0;
            slot_reg <= init_slot;
        end
        else if (shift_en)
        begin
            busy_reg <= d.busy;
            due_reg  <= d.due;
            slot_reg <= d.slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            dl_reg  <= d.dl;
            per_reg <= d.per;
            nd_reg  <= d.nd;
            seq_reg <= d.seq;
        end
    end

    assign q = '{busy: busy_reg, due: due_reg, slot: slot_reg, dl: dl_reg,
                 per: per_reg, nd: nd_reg, seq: seq_reg};
endmodule

### design/dtq_ctrl.sv
// sequencer that works on the head of the ring and feeds its tail
// depends on dtq_pkg
module dtq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 in_mode,
    input  logic [dtq_pkg::TIME_W-1:0] in_time,
    input  logic [dtq_pkg::TIME_W-1:0] in_period,
    input  logic [3:0]                 in_cslot,
    input  logic [dtq_pkg::SEQ_W-1:0]  in_cseq,
    input  dtq_pkg::entry_t            head,
    output dtq_pkg::entry_t            tail,
    output logic                       shift_en,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [1:0]                 out_kind,
    output logic [dtq_pkg::SLOT_W-1:0] out_slot,
    output logic [dtq_pkg::SEQ_W-1:0]  out_seq,
    output logic                       out_ok,
    output logic                       out_changed,
    output logic [dtq_pkg::TIME_W-1:0] out_next,
    output logic                       out_nvalid,
    output logic                       out_last
);
    dtq_pkg::state_t state_reg, state_next;
    logic [dtq_pkg::SLOT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                 mode_reg, mode_next;
    logic [dtq_pkg::TIME_W-1:0] tval_reg, tval_next;
    logic [dtq_pkg::TIME_W-1:0] per_reg, per_next;
    logic [3:0]                 cslot_reg, cslot_next;
    logic [dtq_pkg::SEQ_W-1:0]  cseq_reg, cseq_next;
    logic                       minv_reg, minv_next;
    logic [dtq_pkg::TIME_W-1:0] min_reg, min_next;
    logic [dtq_pkg::SLOT_W-1:0] pslot_reg, pslot_next;
    logic [dtq_pkg::SEQ_W-1:0]  pseq_reg, pseq_next;
    logic                       hit_reg, hit_next;
    logic                       app_reg, app_next;
    logic [dtq_pkg::SLOT_W-1:0] aslot_reg, aslot_next;
    logic [dtq_pkg::TIME_W-1:0] nxt_reg, nxt_next;
    logic                       nv_reg, nv_next;
    logic [dtq_pkg::SEQ_W-1:0]  ctr_reg, ctr_next;
    logic                       ov_reg, ov_next;
    logic [1:0]                 ok_kind_reg, ok_kind_next;
    logic [dtq_pkg::SLOT_W-1:0] o_slot_reg, o_slot_next;
    logic [dtq_pkg::SEQ_W-1:0]  o_seq_reg, o_seq_next;
    logic                       o_ok_reg, o_ok_next;
    logic                       o_ch_reg, o_ch_next;
    logic [dtq_pkg::TIME_W-1:0] o_next_reg, o_next_next;
    logic                       o_nv_reg, o_nv_next;
    logic                       o_last_reg, o_last_next;

    logic                       cand_v;
    logic [dtq_pkg::TIME_W-1:0] cand_dl;
    logic                       take;
    logic [dtq_pkg::TIME_W:0]   sum;
    logic [dtq_pkg::TIME_W-1:0] sat;
    logic                       due;
    logic                       out_free;
    logic                       pass_end;
    logic                       applying;

    assign sum      = {1'b0, tval_reg} + {1'b0, head.per};
    assign sat      = sum[dtq_pkg::TIME_W] ? '1 : sum[dtq_pkg::TIME_W-1:0];
    assign due      = head.busy && (head.dl <= tval_reg);
    assign out_free = !ov_reg || m_tready;
    assign pass_end = (cnt_reg == dtq_pkg::SLOT_W'(dtq_pkg::SLOTS - 1));
    assign applying = app_reg && (head.slot == aslot_reg);
    assign s_tready = (state_reg == dtq_pkg::ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mode_next    = mode_reg;
        tval_next    = tval_reg;
        per_next     = per_reg;
        cslot_next   = cslot_reg;
        cseq_next    = cseq_reg;
        minv_next    = minv_reg;
        min_next     = min_reg;
        pslot_next   = pslot_reg;
        pseq_next    = pseq_reg;
        hit_next     = hit_reg;
        app_next     = app_reg;
        aslot_next   = aslot_reg;
        nxt_next     = nxt_reg;
        nv_next      = nv_reg;
        ctr_next     = ctr_reg;
        ov_next      = ov_reg && !m_tready;
        ok_kind_next = ok_kind_reg;
        o_slot_next  = o_slot_reg;
        o_seq_next   = o_seq_reg;
        o_ok_next    = o_ok_reg;
        o_ch_next    = o_ch_reg;
        o_next_next  = o_next_reg;
        o_nv_next    = o_nv_reg;
        o_last_next  = o_last_reg;
        tail         = head;
        shift_en     = 1'b0;
        cand_v       = 1'b0;
        cand_dl      = head.dl;
        take         = 1'b0;

        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = in_mode;
                    tval_next  = in_time;
                    per_next   = in_period;
                    cslot_next = in_cslot;
                    cseq_next  = in_cseq;
                    minv_next  = 1'b0;
                    min_next   = '0;
                    hit_next   = 1'b0;
                    app_next   = 1'b0;
                    cnt_next   = '0;
                    case (in_mode)
                        dtq_pkg::MODE_ADD:    state_next = dtq_pkg::ST_ADD;
                        dtq_pkg::MODE_CANCEL: state_next = dtq_pkg::ST_CANCEL;
                        dtq_pkg::MODE_TICK:   state_next = dtq_pkg::ST_MARK;
                        default:              state_next = dtq_pkg::ST_IDLE;
                    endcase
                end
            end
            dtq_pkg::ST_ADD:
            begin
                shift_en = 1'b1;
                cand_v   = head.busy;
                if (!head.busy && !hit_reg)
                begin
                    tail.busy  = 1'b1;
                    tail.due   = 1'b0;
                    tail.dl    = tval_reg;
                    tail.per   = per_reg;
                    tail.seq   = ctr_reg;
                    hit_next   = 1'b1;
                    pslot_next = head.slot;
                end
            end
            dtq_pkg::ST_CANCEL:
            begin
                shift_en = 1'b1;
                if (head.busy && ({{(4 - dtq_pkg::SLOT_W){1'b0}}, head.slot} == cslot_reg)
                    && (head.seq == cseq_reg))
                begin
                    tail.busy = 1'b0;
                    hit_next  = 1'b1;
                end
                cand_v = tail.busy;
            end
            dtq_pkg::ST_MARK:
            begin
                shift_en = 1'b1;
                tail.due = due;
                tail.nd  = sat;
                if (due)
                begin
                    cand_v  = (head.per != '0);
                    cand_dl = sat;
                end
                else
                begin
                    cand_v = head.busy;
                end
            end
            dtq_pkg::ST_PICK:
            begin
                shift_en = 1'b1;
                if (applying)
                begin
                    tail.due = 1'b0;
                    if (head.per != '0)
                        tail.dl = head.nd;
                    else
                        tail.busy = 1'b0;
                end
                cand_v = head.due && !applying;
                if (cand_v && (!minv_reg || head.dl < min_reg))
                begin
                    pslot_next = head.slot;
                    pseq_next  = head.seq;
                end
            end
            dtq_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_ch_next   = 1'b0;
                    o_ok_next   = 1'b1;
                    o_last_next = 1'b1;
                    state_next  = dtq_pkg::ST_IDLE;
                    case (mode_reg)
                        dtq_pkg::MODE_ADD:
                        begin
                            ok_kind_next = dtq_pkg::KIND_ADD;
                            o_ok_next    = hit_reg;
                            o_slot_next  = hit_reg ? pslot_reg : '0;
                            o_seq_next   = hit_reg ? ctr_reg : '0;
                            o_ch_next    = hit_reg && (!minv_reg || tval_reg < min_reg);
                            o_nv_next    = minv_reg || hit_reg;
                            if (hit_reg && !(minv_reg && min_reg < tval_reg))
                                o_next_next = tval_reg;
                            else
                                o_next_next = min_reg;
                            if (hit_reg)
                                ctr_next = ctr_reg + 1'b1;
                        end
                        dtq_pkg::MODE_CANCEL:
                        begin
                            ok_kind_next = dtq_pkg::KIND_CANCEL;
                            o_ok_next    = hit_reg;
                            o_slot_next  = cslot_reg[dtq_pkg::SLOT_W-1:0];
                            o_seq_next   = cseq_reg;
                            o_next_next  = min_reg;
                            o_nv_next    = minv_reg;
                        end
                        default:
                        begin
                            o_next_next = nxt_reg;
                            o_nv_next   = nv_reg;
                            if (minv_reg)
                            begin
                                ok_kind_next = dtq_pkg::KIND_EXPIRE;
                                o_slot_next  = pslot_reg;
                                o_seq_next   = pseq_reg;
                                o_last_next  = 1'b0;
                                app_next     = 1'b1;
                                aslot_next   = pslot_reg;
                                minv_next    = 1'b0;
                                min_next     = '0;
                                cnt_next     = '0;
                                state_next   = dtq_pkg::ST_PICK;
                            end
                            else
                            begin
                                ok_kind_next = dtq_pkg::KIND_DONE;
                                o_slot_next  = '0;
                                o_seq_next   = '0;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase

        if (shift_en)
        begin
            take = cand_v && (!minv_reg || cand_dl < min_reg);
            if (take)
            begin
                minv_next = 1'b1;
                min_next  = cand_dl;
            end
            cnt_next = cnt_reg + 1'b1;
            if (pass_end)
            begin
                if (state_reg == dtq_pkg::ST_MARK)
                begin
                    nv_next    = minv_next;
                    nxt_next   = min_next;
                    minv_next  = 1'b0;
                    min_next   = '0;
                    app_next   = 1'b0;
                    state_next = dtq_pkg::ST_PICK;
                end
                else
                begin
                    state_next = dtq_pkg::ST_FIN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtq_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ctr_reg   <= '0;
            ov_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            app_reg   <= 1'b0;
            minv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ctr_reg   <= ctr_next;
            ov_reg    <= ov_next;
            hit_reg   <= hit_next;
            app_reg   <= app_next;
            minv_reg  <= minv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        tval_reg    <= tval_next;
        per_reg     <= per_next;
        cslot_reg   <= cslot_next;
        cseq_reg    <= cseq_next;
        min_reg     <= min_next;
        pslot_reg   <= pslot_next;
        pseq_reg    <= pseq_next;
        aslot_reg   <= aslot_next;
        nxt_reg     <= nxt_next;
        nv_reg      <= nv_next;
        ok_kind_reg <= ok_kind_next;
        o_slot_reg  <= o_slot_next;
        o_seq_reg   <= o_seq_next;
        o_ok_reg    <= o_ok_next;
        o_ch_reg    <= o_ch_next;
        o_next_reg  <= o_next_next;
        o_nv_reg    <= o_nv_next;
        o_last_reg  <= o_last_next;
    end

    assign m_tvalid    = ov_reg;
    assign out_kind    = ok_kind_reg;
    assign out_slot    = o_slot_reg;
    assign out_seq     = o_seq_reg;
    assign out_ok      = o_ok_reg;
    assign out_changed = o_ch_reg;
    assign out_next    = o_next_reg;
    assign out_nvalid  = o_nv_reg;
    assign out_last    = o_last_reg;
endmodule

### design/deadline_timer_queue_core.sv
// top level of the deadline timer queue: ring of slot cells and sequencer
// depends on dtq_pkg, dtq_cell, dtq_ctrl and the assertion macro header
//
// The timer slots sit in a ring of cells that rotates one slot per cycle, while
// a pass runs, past a single compare unit; a pass visits each of the SLOTS (16)
// slots once. Add and cancel take one pass, then the result register is loaded
// and the block returns to idle. A tick takes one marking pass, then one pass
// and one load of the result register per expired timer, and one more of each
// for the done summary.
// A new request is taken only when the previous one has finished its passes;
// each result waits in an output register, and a stalled result holds the
// sequencer until it is taken.
`include "deadline_timer_queue_core_defines.svh"
module deadline_timer_queue_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // time_value, period, cancel_slot, cancel_sequence, zeros
    input  logic [1:0]   s_tuser,  // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,  // slot_index, sequence_number, success,
                                   // earliest_changed, next_deadline, next_valid, zero
    output logic [1:0]   m_tuser,  // kind
    output logic         m_tlast
);
    dtq_pkg::entry_t q [dtq_pkg::SLOTS];
    dtq_pkg::entry_t tail;
    logic            shift_en;
    logic [3:0]      o_slot;
    logic [31:0]     o_seq;
    logic            o_ok;
    logic            o_ch;
    logic [31:0]     o_next;
    logic            o_nv;

    for (genvar i = 0; i < dtq_pkg::SLOTS; i++)
    begin : g_cell
        dtq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .init_slot (dtq_pkg::SLOT_W'(i)),
            .shift_en  (shift_en),
            .d         ((i == dtq_pkg::SLOTS - 1) ? tail : q[(i + 1) % dtq_pkg::SLOTS]),
            .q         (q[i])
        );
    end

    dtq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_mode     (s_tuser),
        .in_time     (s_tdata[31:0]),
        .in_period   (s_tdata[63:32]),
        .in_cslot    (s_tdata[67:64]),
        .in_cseq     (s_tdata[99:68]),
        .head        (q[0]),
        .tail        (tail),
        .shift_en    (shift_en),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_kind    (m_tuser),
        .out_slot    (o_slot),
        .out_seq     (o_seq),
        .out_ok      (o_ok),
        .out_changed (o_ch),
        .out_next    (o_next),
        .out_nvalid  (o_nv),
        .out_last    (m_tlast)
    );

    assign m_tdata = {1'b0, o_nv, o_next, o_ch, o_ok, o_seq, o_slot};

    `DTQ_ASSERT_IMPL(a_done_last, clk, rst_n, m_tvalid && (m_tuser == dtq_pkg::KIND_DONE), m_tlast)
    `DTQ_ASSERT_IMPL(a_expire_not_last, clk, rst_n, m_tvalid && (m_tuser == dtq_pkg::KIND_EXPIRE), !m_tlast)
    `DTQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, s_tvalid && s_tready && (s_tuser != dtq_pkg::MODE_NOP), !s_tready)
    `DTQ_ASSERT_IMPL(a_ring_aligned, clk, rst_n, s_tready, q[0].slot == '0)
endmodule
